/* sv/scsp_pkg.sv */
// shared types and constants for the spi command slave framer
package scsp_pkg;

  localparam logic [7:0] HEADER_BYTE   = 8'hAA;
  localparam logic [7:0] CMD_MOTOR_A   = 8'h01;
  localparam logic [7:0] CMD_MOTOR_B   = 8'h02;
  localparam logic [7:0] CMD_MOTOR_AB  = 8'h05;
  localparam logic [7:0] CMD_SERVO_LO  = 8'h11;
  localparam logic [7:0] CMD_SERVO_HI  = 8'h18;
  localparam logic [7:0] CMD_SENSOR_1  = 8'h21;
  localparam logic [7:0] CMD_SENSOR_2  = 8'h22;
  localparam logic [7:0] CMD_CONST_LO  = 8'h51;
  localparam logic [7:0] CMD_CONST_HI  = 8'h58;
  localparam logic [7:0] CONST_BASE    = 8'h50;

  localparam logic [15:0] SERVO_CENTER_RST = 16'd1500;
  localparam logic [7:0]  STATUS_RST       = 8'd17;
  localparam logic [7:0]  DATA_HIGH_RST    = 8'd1;
  localparam logic [7:0]  DATA_LOW_RST     = 8'd2;

  // byte positions inside a frame
  localparam logic [2:0] POS_IDLE   = 3'd0;
  localparam logic [2:0] POS_CMD    = 3'd1;
  localparam logic [2:0] POS_VHIGH  = 3'd2;
  localparam logic [2:0] POS_VLOW   = 3'd3;
  localparam logic [2:0] POS_FILL1  = 3'd4;
  localparam logic [2:0] POS_FILL2  = 3'd5;
  localparam logic [2:0] POS_CSUM   = 3'd6;
  localparam logic [2:0] POS_TRAIL  = 3'd7;

  // configuration register indexes
  localparam logic REG_SERVO_CENTER = 1'b0;
  localparam logic REG_STATUS       = 1'b1;

  typedef struct packed {
    logic        a_update;
    logic [14:0] a_forward;
    logic [15:0] a_reverse;
    logic        b_update;
    logic [14:0] b_forward;
    logic [15:0] b_reverse;
    logic        s_update;
    logic [2:0]  s_index;
    logic [15:0] s_pulse;
  } act_t;

endpackage

/* sv/scsp_exec.sv */
// command decode for motor and servo compare writes
module scsp_exec
  import scsp_pkg::*;
(
  input  logic [7:0]  cmd,
  input  logic [15:0] value,
  input  logic [15:0] servo_center,
  output logic        hit,
  output act_t        act
);

  logic [14:0] fwd;
  logic [15:0] rev;
  logic        is_a;
  logic        is_b;
  logic        is_servo;
  logic [7:0]  servo_off;

  // sign and magnitude split of the signed value
  assign fwd = value[15] ? 15'd0 : value[14:0];
  assign rev = value[15] ? (~value + 16'd1) : 16'd0;

  assign is_a     = (cmd == CMD_MOTOR_A) || (cmd == CMD_MOTOR_AB);
  assign is_b     = (cmd == CMD_MOTOR_B) || (cmd == CMD_MOTOR_AB);
  assign is_servo = (cmd >= CMD_SERVO_LO) && (cmd <= CMD_SERVO_HI);
  assign servo_off = cmd - CMD_SERVO_LO;

  assign hit = is_a || is_b || is_servo;

  always_comb begin
    act = '0;
    if (is_a) begin
      act.a_update  = 1'b1;
      act.a_forward = fwd;
      act.a_reverse = rev;
    end
    if (is_b) begin
      act.b_update  = 1'b1;
      act.b_forward = fwd;
      act.b_reverse = rev;
    end
    if (is_servo) begin
      act.s_update = 1'b1;
      act.s_index  = servo_off[2:0];
      act.s_pulse  = servo_center + value;
    end
  end

endmodule

/* sv/spi_command_slave_pwm_top.sv */
// top level of the spi command slave framer with motor and servo compares
// the result of each input transfer is registered in the output register
// throughput: one byte per cycle, set by the single state update ahead of the result register
// the output register stalls input only while a held result is not taken
// reset: synchronous active high; frame state idle, reply data 1 and 2, servo centre 1500,
// status byte 17
module spi_command_slave_pwm_top
  import scsp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // rx_byte[7:0], sensor_one[23:8], sensor_two[39:24]
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  // reply_valid[0], reply_byte[8:1], motor_a_update[9], motor_a_forward[24:10],
  // motor_a_reverse[40:25], motor_b_update[41], motor_b_forward[56:42],
  // motor_b_reverse[72:57], servo_update[73], servo_index[76:74], servo_pulse[92:77],
  // zero fill [95:93]
  output logic [95:0] m_tdata,
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  // configuration registers
  logic [15:0] servo_center;
  logic [7:0]  status_byte;

  // frame state
  logic        in_frame, in_frame_next;
  logic [2:0]  byte_position, byte_position_next;
  logic [7:0]  command_byte, command_byte_next;
  logic [7:0]  value_high, value_high_next;
  logic [7:0]  value_low, value_low_next;
  logic [7:0]  reply_data_high, reply_data_high_next;
  logic [7:0]  reply_data_low, reply_data_low_next;
  logic        ack_flag, ack_flag_next;

  // result register
  logic        out_valid;
  logic        res_reply_valid, res_reply_valid_next;
  logic [7:0]  res_reply_byte, res_reply_byte_next;
  act_t        res_act, res_act_next;

  logic        accept;
  logic [7:0]  rx_byte;
  logic [15:0] sensor_one;
  logic [15:0] sensor_two;
  logic [7:0]  csum;
  logic        exec_hit;
  act_t        exec_act;
  logic [7:0]  const_val;

  assign rx_byte    = s_tdata[7:0];
  assign sensor_one = s_tdata[23:8];
  assign sensor_two = s_tdata[39:24];

  // result register frees up in the same cycle it is taken
  assign s_tready  = !out_valid || m_tready;
  assign accept    = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  // checksum of the frame in flight
  assign csum = HEADER_BYTE + command_byte + value_high + value_low;

  scsp_exec u_exec (
    .cmd          (command_byte),
    .value        ({value_high, value_low}),
    .servo_center (servo_center),
    .hit          (exec_hit),
    .act          (exec_act)
  );

  assign const_val = command_byte_next - CONST_BASE;

  always_comb begin
    in_frame_next        = in_frame;
    byte_position_next   = byte_position;
    command_byte_next    = command_byte;
    value_high_next      = value_high;
    value_low_next       = value_low;
    ack_flag_next        = ack_flag;
    res_reply_valid_next = 1'b0;
    res_reply_byte_next  = 8'd0;
    res_act_next         = '0;

    if (!in_frame) begin
      if (rx_byte == HEADER_BYTE) begin
        in_frame_next        = 1'b1;
        byte_position_next   = POS_CMD;
        ack_flag_next        = 1'b0;
        res_reply_valid_next = 1'b1;
        res_reply_byte_next  = status_byte;
      end else begin
        byte_position_next = POS_IDLE;
      end
    end else begin
      case (byte_position)
        POS_CMD: begin
          command_byte_next    = rx_byte;
          res_reply_valid_next = 1'b1;
          res_reply_byte_next  = status_byte;
          byte_position_next   = POS_VHIGH;
        end
        POS_VHIGH: begin
          value_high_next      = rx_byte;
          res_reply_valid_next = 1'b1;
          res_reply_byte_next  = command_byte;
          byte_position_next   = POS_VLOW;
        end
        POS_VLOW: begin
          value_low_next       = rx_byte;
          res_reply_valid_next = 1'b1;
          res_reply_byte_next  = reply_data_high;
          byte_position_next   = POS_FILL1;
        end
        POS_FILL1: begin
          res_reply_valid_next = 1'b1;
          res_reply_byte_next  = reply_data_low;
          byte_position_next   = POS_FILL2;
        end
        POS_FILL2: begin
          res_reply_valid_next = 1'b1;
          res_reply_byte_next  = reply_data_high + reply_data_low;
          byte_position_next   = POS_CSUM;
        end
        POS_CSUM: begin
          // actuators written only on a good checksum
          if ((csum == rx_byte) && exec_hit) begin
            ack_flag_next = 1'b1;
            res_act_next  = exec_act;
          end
          res_reply_valid_next = 1'b1;
          res_reply_byte_next  = {7'd0, ack_flag_next};
          byte_position_next   = POS_TRAIL;
        end
        default: begin
          // trailing byte or stray position closes the frame
          in_frame_next      = 1'b0;
          byte_position_next = POS_IDLE;
        end
      endcase
    end

    // reply data follows the latest sensor or constant command on every transfer
    reply_data_high_next = reply_data_high;
    reply_data_low_next  = reply_data_low;
    if (command_byte_next == CMD_SENSOR_1) begin
      reply_data_high_next = sensor_one[15:8];
      reply_data_low_next  = sensor_one[7:0];
    end else if (command_byte_next == CMD_SENSOR_2) begin
      reply_data_high_next = sensor_two[15:8];
      reply_data_low_next  = sensor_two[7:0];
    end else if ((command_byte_next >= CMD_CONST_LO) &&
                 (command_byte_next <= CMD_CONST_HI)) begin
      reply_data_high_next = 8'd0;
      reply_data_low_next  = const_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      servo_center    <= SERVO_CENTER_RST;
      status_byte     <= STATUS_RST;
      in_frame        <= 1'b0;
      byte_position   <= POS_IDLE;
      command_byte    <= 8'd0;
      value_high      <= 8'd0;
      value_low       <= 8'd0;
      reply_data_high <= DATA_HIGH_RST;
      reply_data_low  <= DATA_LOW_RST;
      ack_flag        <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SERVO_CENTER: servo_center <= cfg_data;
          REG_STATUS:       status_byte  <= cfg_data[7:0];
          default:          servo_center <= servo_center;
        endcase
      end
      if (accept) begin
        in_frame        <= in_frame_next;
        byte_position   <= byte_position_next;
        command_byte    <= command_byte_next;
        value_high      <= value_high_next;
        value_low       <= value_low_next;
        reply_data_high <= reply_data_high_next;
        reply_data_low  <= reply_data_low_next;
        ack_flag        <= ack_flag_next;
        out_valid       <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      res_reply_valid <= res_reply_valid_next;
      res_reply_byte  <= res_reply_byte_next;
      res_act         <= res_act_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {3'd0,
                     res_act.s_pulse, res_act.s_index, res_act.s_update,
                     res_act.b_reverse, res_act.b_forward, res_act.b_update,
                     res_act.a_reverse, res_act.a_forward, res_act.a_update,
                     res_reply_byte, res_reply_valid};

`ifndef SYNTH
  // idle framer always sits at the idle position
  a_idle_pos: assert property (@(posedge clk) disable iff (rst)
    !in_frame |-> (byte_position == POS_IDLE))
    else $error("idle framer with non-zero byte position");

  // inside a frame the position is never idle
  a_frame_pos: assert property (@(posedge clk) disable iff (rst)
    in_frame |-> (byte_position != POS_IDLE))
    else $error("frame open at idle position");

  // an actuator write always comes with an ack reply of one
  a_ack: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (res_act.a_update || res_act.b_update || res_act.s_update)) |->
      (res_reply_valid && (res_reply_byte == 8'd1)))
    else $error("actuator write without ack");

  // servo and motor writes never share one result
  a_excl: assert property (@(posedge clk) disable iff (rst)
    (out_valid && res_act.s_update) |-> (!res_act.a_update && !res_act.b_update))
    else $error("servo and motor written together");
`endif

endmodule
